// File: rtl/core/mrrc_pkg.sv
// ----------------------------------------------------------------------------
// mrrc_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the
// Modbus RTU response checker.
// ----------------------------------------------------------------------------
package mrrc_pkg;

  localparam int MaxFrameBytes = 256;
  localparam int SeenW         = $clog2(MaxFrameBytes + 2);
  localparam int QDepth        = 4;
  localparam int QAw           = $clog2(QDepth);
  localparam int QCw           = $clog2(QDepth + 1);
  localparam int PaddrW        = 3;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadCrc   = 3'd1;
  localparam logic [2:0] StBadAddr  = 3'd2;
  localparam logic [2:0] StBadFunc  = 3'd3;
  localparam logic [2:0] StBadLen   = 3'd4;

  localparam logic KindValue  = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam logic [PaddrW-1:0] AddrDevice   = PaddrW'(0);
  localparam logic [PaddrW-1:0] AddrFunction = PaddrW'(4);

  typedef struct packed {
    logic        has_val;
    logic [15:0] val;
    logic [6:0]  idx;
    logic        has_stat;
    logic [2:0]  status;
  } mrrc_entry_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/mrrc_front.sv
// ----------------------------------------------------------------------------
// mrrc_front
// Byte intake: delay line, CRC accumulator, header checks and register
// pairing. Builds one queue entry per byte that causes any result.
// ----------------------------------------------------------------------------
module mrrc_front import mrrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  input  logic [7:0]  dev_addr_i,
  input  logic [7:0]  func_code_i,
  output logic        push_o,
  output mrrc_entry_t entry_o
);

  localparam logic [SeenW-1:0] SeenTwo   = SeenW'(2);
  localparam logic [SeenW-1:0] SeenThree = SeenW'(3);
  localparam logic [SeenW-1:0] SeenFour  = SeenW'(4);
  localparam logic [SeenW-1:0] SeenOne   = SeenW'(1);
  localparam logic [SeenW-1:0] SeenZero  = SeenW'(0);
  localparam logic [SeenW-1:0] SeenMax   = SeenW'(MaxFrameBytes);
  localparam logic [SeenW-1:0] SeenSat   = SeenW'(MaxFrameBytes + 1);

  logic [15:0]      crc_q, crc_d;
  logic [7:0]       dly0_q, dly0_d, dly1_q, dly1_d;
  logic [SeenW-1:0] seen_q, seen_d;
  logic [7:0]       decl_q, decl_d;
  logic             addr_ok_q, addr_ok_d;
  logic             func_ok_q, func_ok_d;
  logic [7:0]       hold_q, hold_d;
  logic             phase_q, phase_d;
  logic [6:0]       rcnt_q, rcnt_d;
  mrrc_entry_t      entry;

  always_comb begin
    crc_d     = crc_q;
    dly0_d    = rx_byte_i;
    dly1_d    = dly0_q;
    seen_d    = seen_q;
    decl_d    = decl_q;
    addr_ok_d = addr_ok_q;
    func_ok_d = func_ok_q;
    hold_d    = hold_q;
    phase_d   = phase_q;
    rcnt_d    = rcnt_q;
    entry     = '0;

    if (seen_q >= SeenTwo) begin
      crc_d = crc_byte(crc_q, dly1_q);
      if (seen_q <= SeenMax) begin
        if (seen_q == SeenTwo) begin
          addr_ok_d = (dly1_q == dev_addr_i);
        end else if (seen_q == SeenThree) begin
          func_ok_d = (dly1_q == func_code_i);
        end else if (seen_q == SeenFour) begin
          decl_d = dly1_q;
        end else if (!phase_q) begin
          hold_d  = dly1_q;
          phase_d = 1'b1;
        end else begin
          entry.has_val = 1'b1;
          entry.val     = {hold_q, dly1_q};
          entry.idx     = rcnt_q;
          rcnt_d        = rcnt_q + 7'd1;
          phase_d       = 1'b0;
        end
      end
    end

    if (seen_q != SeenSat) begin
      seen_d = seen_q + SeenOne;
    end

    if (frame_end_i) begin
      if (phase_d) begin
        entry.has_val = 1'b1;
        entry.val     = {8'h00, hold_d};
        entry.idx     = rcnt_d;
      end
      entry.has_stat = 1'b1;
      if (seen_q == SeenZero || {rx_byte_i, dly0_q} != crc_d) begin
        entry.status = StBadCrc;
      end else if (seen_q == SeenOne || !addr_ok_d) begin
        entry.status = StBadAddr;
      end else if (seen_q == SeenTwo || !func_ok_d) begin
        entry.status = StBadFunc;
      end else if (seen_q == SeenThree || seen_q >= SeenMax ||
                   {1'b0, decl_d} != seen_q - SeenFour) begin
        entry.status = StBadLen;
      end else begin
        entry.status = StOk;
      end
      crc_d     = CrcInit;
      dly0_d    = '0;
      dly1_d    = '0;
      seen_d    = '0;
      decl_d    = '0;
      addr_ok_d = 1'b0;
      func_ok_d = 1'b0;
      hold_d    = '0;
      phase_d   = 1'b0;
      rcnt_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= CrcInit;
      dly0_q    <= '0;
      dly1_q    <= '0;
      seen_q    <= '0;
      decl_q    <= '0;
      addr_ok_q <= 1'b0;
      func_ok_q <= 1'b0;
      hold_q    <= '0;
      phase_q   <= 1'b0;
      rcnt_q    <= '0;
    end else if (accept_i) begin
      crc_q     <= crc_d;
      dly0_q    <= dly0_d;
      dly1_q    <= dly1_d;
      seen_q    <= seen_d;
      decl_q    <= decl_d;
      addr_ok_q <= addr_ok_d;
      func_ok_q <= func_ok_d;
      hold_q    <= hold_d;
      phase_q   <= phase_d;
      rcnt_q    <= rcnt_d;
    end
  end

  assign push_o  = accept_i && (entry.has_val || entry.has_stat);
  assign entry_o = entry;

endmodule

// File: rtl/core/mrrc_fifo.sv
// ----------------------------------------------------------------------------
// mrrc_fifo
// Short queue of result entries between the byte intake and the output side.
// ----------------------------------------------------------------------------
module mrrc_fifo import mrrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  mrrc_entry_t entry_i,
  input  logic        pop_i,
  output logic        full_o,
  output logic        empty_o,
  output mrrc_entry_t head_o
);

  mrrc_entry_t        mem_q [QDepth];
  logic [QAw-1:0]     wptr_q, rptr_q;
  logic [QCw-1:0]     cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCw'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCw'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCw'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + QAw'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + QAw'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/core/mrrc_back.sv
// ----------------------------------------------------------------------------
// mrrc_back
// Output side: splits a queue entry into value and status beats and holds
// each beat in the output register until taken.
// ----------------------------------------------------------------------------
module mrrc_back import mrrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  mrrc_entry_t head_i,
  output logic        pop_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic        kind_o,
  output logic [15:0] reg_value_o,
  output logic [6:0]  reg_index_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  logic        valid_q;
  logic        kind_q, kind_d;
  logic [15:0] value_q, value_d;
  logic [6:0]  index_q, index_d;
  logic [2:0]  status_q, status_d;
  logic        last_q, last_d;
  logic        split_q, split_d;
  logic        load;

  assign load = !empty_i && (!valid_q || !out_stall_i);

  always_comb begin
    kind_d   = KindStatus;
    value_d  = '0;
    index_d  = '0;
    status_d = head_i.status;
    last_d   = 1'b1;
    split_d  = 1'b0;
    pop_o    = load;
    if (head_i.has_val && !split_q) begin
      kind_d   = KindValue;
      value_d  = head_i.val;
      index_d  = head_i.idx;
      status_d = StOk;
      last_d   = 1'b0;
      split_d  = head_i.has_stat;
      pop_o    = load && !head_i.has_stat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      split_q <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= !empty_i;
      if (load) begin
        split_q <= split_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= kind_d;
      value_q  <= value_d;
      index_q  <= index_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign reg_value_o = value_q;
  assign reg_index_o = index_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

// File: rtl/core/modbus_rtu_response_checker.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker
// Checks one Modbus RTU read response per frame and emits register values
// and a closing frame status.
//
// Input channel: one response byte per beat (rx_byte_i, frame_end_i on the
// final byte), in_valid_i / in_stall_o. Output channel: out_valid_o /
// out_stall_i; a value beat (kind 0) per register pair as the pair leaves
// the two-byte CRC delay, a trailing odd byte as a one-byte value, then one
// status beat (kind 1, last 1) at frame end.
// A result is registered in the result queue and then in the output
// register, from which it reaches the outputs. Throughput: one byte per
// cycle while in_stall_o is low; the byte closing a frame that carries
// data bytes yields a value beat and the status beat as separate beats.
// The CRC-16 byte update is combinational in the intake stage.
// A four-entry result queue parts intake from output; when the receiver
// stalls, the queue fills and in_stall_o stays high while it is full.
// Reset clears the frame state, the queue and the output register, and
// sets device_address to 1 and function_code to 3 (APB offsets 0 and 4).
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker import mrrc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              frame_end_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              kind_o,
  output logic [15:0]       reg_value_o,
  output logic [6:0]        reg_index_o,
  output logic [2:0]        status_o,
  output logic              last_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0]  dev_addr_q;
  logic [7:0]  func_code_q;
  logic        cfg_wr;
  logic        accept;
  logic        full, empty, push, pop;
  mrrc_entry_t entry, head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= 8'd1;
      func_code_q <= 8'd3;
    end else if (cfg_wr) begin
      if (paddr[2] == AddrFunction[2]) begin
        func_code_q <= pwdata[7:0];
      end else begin
        dev_addr_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    case (paddr)
      AddrDevice:   prdata = {24'h0, dev_addr_q};
      AddrFunction: prdata = {24'h0, func_code_q};
      default:      prdata = '0;
    endcase
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  mrrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .frame_end_i (frame_end_i),
    .dev_addr_i  (dev_addr_q),
    .func_code_i (func_code_q),
    .push_o      (push),
    .entry_o     (entry)
  );

  mrrc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  mrrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o),
    .reg_value_o (reg_value_o),
    .reg_index_o (reg_index_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

// File: rtl/core/mrrc_checker.sv
// ----------------------------------------------------------------------------
// mrrc_checker
// Port-level checks on the response checker's output beats, bound to the
// top level.
// ----------------------------------------------------------------------------
module mrrc_checker import mrrc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic [15:0] reg_value_o,
  input logic [6:0]  reg_index_o,
  input logic [2:0]  status_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(reg_value_o) && $stable(reg_index_o) && $stable(status_o) &&
      $stable(last_o))
    else $error("output beat changed while stalled");

  a_status_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindStatus |->
      last_o && reg_value_o == '0 && reg_index_o == '0)
    else $error("status beat carries value fields or lacks last");

  a_value_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindValue |-> !last_o && status_o == StOk)
    else $error("value beat carries status or last");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindStatus |->
      status_o == StOk || status_o == StBadCrc || status_o == StBadAddr ||
      status_o == StBadFunc || status_o == StBadLen)
    else $error("status code out of range");

endmodule

bind modbus_rtu_response_checker mrrc_checker u_mrrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .reg_value_o (reg_value_o),
  .reg_index_o (reg_index_o),
  .status_o    (status_o),
  .last_o      (last_o)
);
